/* rtl/sgr_pkg.sv */
// Shared types and constants of the stream grouping router.
// Used by every module of the block; depends on nothing else.
package sgr_pkg;

  localparam logic [2:0] MODE_SHUFFLE = 3'd0;
  localparam logic [2:0] MODE_KEY     = 3'd1;
  localparam logic [2:0] MODE_BCAST   = 3'd2;
  localparam logic [2:0] MODE_MCAST   = 3'd3;
  localparam logic [2:0] MODE_POC     = 3'd4;

  localparam logic [1:0] CFG_MODE        = 2'd0;
  localparam logic [1:0] CFG_NUM_TARGETS = 2'd1;
  localparam logic [1:0] CFG_NUM_CHOICES = 2'd2;

  localparam logic [63:0] HASH_INIT = 64'd37;
  localparam logic [63:0] HASH_MUL  = 64'd54059;
  localparam logic signed [25:0] BYTE_MUL = 26'sd76963;

  localparam int DIV_BITS = 4;

  typedef struct packed {
    logic [63:0] hash;
    logic [2:0]  mode;
    logic [6:0]  num_targets;
    logic [4:0]  num_choices;
  } job_t;

endpackage

/* rtl/stream_grouping_router_unit.sv */
// Stream grouping router top level: configuration registers, hashing
// front, job queue and routing back. Depends on sgr_pkg and all rtl modules.
//
// Key bytes are taken one per cycle while the job queue is not full; those
// flagged has_byte are folded into a 64-bit hash. A byte marked last ends
// the key and queues it for routing (two keys may wait). The shuffle, key,
// multicast and power-of-choices modes first run the remainder unit, then
// emit one route per cycle while the output is not stalled; broadcast does
// the same with no remainder pass; power of choices reads and then compares
// the load of each candidate, then writes the chosen load back. The front
// keeps taking key bytes while the back end works. Load counters start at
// zero after reset at once.
module stream_grouping_router_unit
  import sgr_pkg::*;
#(
  parameter int MAX_TARGETS = 64,
  parameter int MAX_CHOICES = 16,
  parameter int LOAD_WIDTH  = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // key_byte[7:0]
  input  logic       s_tuser,   // has_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // route[5:0], zero[7:6]
  output logic       m_tlast,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);

  logic [2:0] mode;
  logic [6:0] num_targets;
  logic [4:0] num_choices;
  logic       push;
  job_t       push_job;
  logic       queue_full;
  logic       job_avail;
  logic       job_pop;
  job_t       job_head;
  logic [5:0] route;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_KEY;
      num_targets <= 7'd1;
      num_choices <= 5'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODE:        mode        <= cfg_data[2:0];
        CFG_NUM_TARGETS: num_targets <= cfg_data;
        CFG_NUM_CHOICES: num_choices <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  sgr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .s_tlast     (s_tlast),
    .mode        (mode),
    .num_targets (num_targets),
    .num_choices (num_choices),
    .queue_full  (queue_full),
    .push        (push),
    .push_job    (push_job)
  );

  sgr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (queue_full),
    .pop      (job_pop),
    .avail    (job_avail),
    .head     (job_head)
  );

  sgr_back #(
    .MAX_TARGETS (MAX_TARGETS),
    .MAX_CHOICES (MAX_CHOICES),
    .LOAD_WIDTH  (LOAD_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .job_avail  (job_avail),
    .job_in     (job_head),
    .job_pop    (job_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .route      (route),
    .last_route (m_tlast)
  );

  assign m_tdata = {2'b00, route};

endmodule

/* rtl/sgr_queue.sv */
// Two-entry job queue between the hashing front and the routing back.
// Depends on sgr_pkg for the job type.
module sgr_queue
  import sgr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic avail,
  output job_t head
);

  job_t       mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign avail = (count != 2'd0);
  assign head  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

/* rtl/sgr_front.sv */
// Front end: accepts key bytes, folds them into the running hash and
// queues one routing job per key. Depends on sgr_pkg.
module sgr_front
  import sgr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tuser,
  input  logic       s_tlast,
  input  logic [2:0] mode,
  input  logic [6:0] num_targets,
  input  logic [4:0] num_choices,
  input  logic       queue_full,
  output logic       push,
  output job_t       push_job
);

  logic [63:0]        hash;
  logic [63:0]        folded;
  logic signed [25:0] byte_ext;
  logic signed [25:0] byte_prod;
  logic               accept;

  assign s_tready  = !queue_full;
  assign accept    = s_tvalid && s_tready;
  assign byte_ext  = {{18{s_tdata[7]}}, s_tdata};
  assign byte_prod = byte_ext * BYTE_MUL;

  always_comb begin
    folded = hash;
    if (s_tuser) begin
      folded = 64'(hash * HASH_MUL) ^ {{38{byte_prod[25]}}, byte_prod};
    end
  end

  assign push                 = accept && s_tlast;
  assign push_job.hash        = folded;
  assign push_job.mode        = mode;
  assign push_job.num_targets = num_targets;
  assign push_job.num_choices = num_choices;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= HASH_INIT;
    end else if (accept) begin
      hash <= s_tlast ? HASH_INIT : folded;
    end
  end

endmodule

/* rtl/sgr_mod.sv */
// Iterative remainder unit: 64-bit dividend modulo a divisor of 1 to 64,
// four dividend bits per cycle. Depends on sgr_pkg.
module sgr_mod
  import sgr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [6:0]  divisor,
  output logic        busy,
  output logic        done,
  output logic [5:0]  rem
);

  localparam int STEPS = 64 / DIV_BITS;

  logic [3:0]  cnt;
  logic [63:0] q;
  logic [6:0]  r;
  logic [6:0]  d;
  logic [6:0]  r_new;

  always_comb begin
    logic [6:0] t;
    r_new = r;
    for (int k = 0; k < DIV_BITS; k++) begin
      t = {r_new[5:0], q[63-k]};
      if (t >= d) begin
        t = t - d;
      end
      r_new = t;
    end
  end

  assign rem = r[5:0];

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= 7'd0;
      d <= divisor;
    end else if (busy) begin
      q <= q << DIV_BITS;
      r <= r_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 4'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 4'd0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/sgr_back.sv */
// Back end: takes queued jobs, computes the routes with the remainder unit
// and the load memory, and drives the result stream. Depends on sgr_pkg, sgr_mod.
module sgr_back
  import sgr_pkg::*;
#(
  parameter int MAX_TARGETS = 64,
  parameter int MAX_CHOICES = 16,
  parameter int LOAD_WIDTH  = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       job_avail,
  input  job_t       job_in,
  output logic       job_pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [5:0] route,
  output logic       last_route
);

  localparam int IDX_W = $clog2(MAX_TARGETS);
  localparam logic [LOAD_WIDTH-1:0] LOAD_CAP = '1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_ROUTE = 6'b000100,
    S_RD    = 6'b001000,
    S_CMP   = 6'b010000,
    S_WR    = 6'b100000
  } state_t;

  state_t          state;
  logic [2:0]      mode;
  logic [6:0]      n;
  logic [6:0]      total;
  logic [6:0]      idx;
  logic [5:0]      cur;
  logic [63:0]     sum;
  logic [5:0]      rr;
  logic [5:0]      best;
  logic [LOAD_WIDTH-1:0] best_load;

  logic [LOAD_WIDTH-1:0] load_mem [MAX_TARGETS];
  logic [MAX_TARGETS-1:0] load_valid;
  logic [LOAD_WIDTH-1:0] rd_data;
  logic                  rd_valid;
  logic [LOAD_WIDTH-1:0] load;
  logic                  wr_en;

  logic [6:0]  n_eff;
  logic [4:0]  c_eff;
  logic        div_start;
  logic [63:0] div_dividend;
  logic        div_busy;
  logic        div_done;
  logic [5:0]  div_rem;
  logic        can_emit;
  logic        route_fire;
  logic [5:0]  cur_step;
  logic [63:0] sum_step;

  sgr_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (n_eff),
    .busy     (div_busy),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    n_eff = job_in.num_targets;
    if (job_in.num_targets == 7'd0) begin
      n_eff = 7'd1;
    end else if (int'(job_in.num_targets) > MAX_TARGETS) begin
      n_eff = 7'(MAX_TARGETS);
    end
    c_eff = job_in.num_choices;
    if (job_in.num_choices == 5'd0) begin
      c_eff = 5'd1;
    end else if (int'(job_in.num_choices) > MAX_CHOICES) begin
      c_eff = 5'(MAX_CHOICES);
    end
  end

  assign job_pop   = (state == S_IDLE) && job_avail;
  assign div_start = job_pop && (job_in.mode == MODE_SHUFFLE || job_in.mode == MODE_KEY ||
                                 job_in.mode == MODE_MCAST || job_in.mode == MODE_POC);
  assign div_dividend = (job_in.mode == MODE_SHUFFLE) ? {57'd0, {1'b0, rr} + 7'd1}
                                                      : job_in.hash;
  assign can_emit   = !m_tvalid || m_tready;
  assign route_fire = (state == S_ROUTE) && can_emit;
  assign load       = rd_valid ? rd_data : '0;
  assign wr_en      = (state == S_WR) && (best_load != LOAD_CAP);
  assign sum_step   = sum + 64'd1;

  always_comb begin
    if (sum_step == 64'd0 || {1'b0, cur} + 7'd1 == n) begin
      cur_step = 6'd0;
    end else begin
      cur_step = cur + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= load_mem[cur[IDX_W-1:0]];
    if (wr_en) begin
      load_mem[best[IDX_W-1:0]] <= best_load + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_valid <= '0;
      rd_valid   <= 1'b0;
    end else begin
      rd_valid <= load_valid[cur[IDX_W-1:0]];
      if (wr_en) begin
        load_valid[best[IDX_W-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rr       <= 6'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !route_fire) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (job_pop) begin
            mode <= job_in.mode;
            n    <= n_eff;
            sum  <= job_in.hash;
            idx  <= 7'd0;
            cur  <= 6'd0;
            if (job_in.mode == MODE_BCAST) begin
              total <= n_eff;
              state <= S_ROUTE;
            end else if (div_start) begin
              total <= (job_in.mode == MODE_MCAST) ? {2'd0, c_eff} : 7'd1;
              if (job_in.mode == MODE_POC) begin
                best <= {1'b0, c_eff};
              end
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            cur <= div_rem;
            if (mode == MODE_SHUFFLE) begin
              rr <= div_rem;
            end
            if (mode == MODE_POC) begin
              total <= {2'd0, best[4:0]};
              state <= S_RD;
            end else begin
              state <= S_ROUTE;
            end
          end
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (idx == 7'd0 || load < best_load) begin
            best      <= cur;
            best_load <= load;
          end
          idx <= idx + 7'd1;
          if (idx + 7'd1 == total) begin
            state <= S_WR;
          end else begin
            cur   <= cur_step;
            sum   <= sum_step;
            state <= S_RD;
          end
        end
        S_WR: begin
          cur   <= best;
          idx   <= 7'd0;
          total <= 7'd1;
          state <= S_ROUTE;
        end
        S_ROUTE: begin
          if (can_emit) begin
            m_tvalid   <= 1'b1;
            route      <= cur;
            last_route <= (idx + 7'd1 == total);
            idx        <= idx + 7'd1;
            if (mode == MODE_BCAST) begin
              cur <= cur + 6'd1;
            end else begin
              cur <= cur_step;
              sum <= sum_step;
            end
            if (idx + 7'd1 == total) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_cmp_after_rd: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> ($past(state) == S_RD))
    else $error("compare step without a preceding read");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("remainder finished outside the wait state");

  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DIV) && !div_done) |-> div_busy)
    else $error("waiting on an idle remainder unit");

  a_wr_mode: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |-> (mode == MODE_POC))
    else $error("load update outside power-of-choices mode");

endmodule
